// File: sv/hbsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbsd_pkg: shared types and constants of the Huffman bit-serial decoder
// Field widths, stream packing, operation and status codes, result struct.
// ----------------------------------------------------------------------------
package hbsd_pkg;

    // defaults for the top-level parameters
    localparam int DEF_MAX_NODES    = 512;
    localparam int DEF_MAX_CODE_LEN = 16;
    localparam int DEF_SYMBOL_BITS  = 16;

    // fixed field widths
    localparam int CODE_W   = 16;
    localparam int LEN_W    = 5;
    localparam int SYM_W    = 16;
    localparam int STATUS_W = 2;

    // stream widths, zero-filled to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    // input tdata layout
    localparam int S_BITS_LSB = 0;
    localparam int S_LEN_LSB  = S_BITS_LSB + CODE_W;
    localparam int S_SYM_LSB  = S_LEN_LSB + LEN_W;
    localparam int S_DBIT_LSB = S_SYM_LSB + SYM_W;

    // output tdata layout
    localparam int M_STATUS_LSB = 0;
    localparam int M_LEAF_LSB   = M_STATUS_LSB + STATUS_W;
    localparam int M_SYM_LSB    = M_LEAF_LSB + 1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FAIL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic                    operation;
        logic [CODE_W-1:0]       code_bits;
        logic [LEN_W-1:0]        code_length;
        logic signed [SYM_W-1:0] code_symbol;
        logic                    data_bit;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic                    is_leaf;
        logic signed [SYM_W-1:0] symbol;
    } t_result;

endpackage

// File: sv/hbsd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbsd_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module hbsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/hbsd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbsd_out_reg: result output register
// Holds one finished result until the downstream side takes it.
// ----------------------------------------------------------------------------
module hbsd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  hbsd_pkg::t_result i_result,
    output logic              o_valid,
    input  logic              i_ready,
    output hbsd_pkg::t_result o_result
);

    logic              r_valid;
    hbsd_pkg::t_result r_result;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: sv/hbsd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbsd_ctrl: tree walk sequencer
// Read-modify-write of the node memory for inserts, child step and leaf
// check for decodes. Entry layout: {left child, right child, symbol}.
// ----------------------------------------------------------------------------
module hbsd_ctrl #(
    parameter int MAX_NODES    = hbsd_pkg::DEF_MAX_NODES,
    parameter int MAX_CODE_LEN = hbsd_pkg::DEF_MAX_CODE_LEN,
    parameter int SYMBOL_BITS  = hbsd_pkg::DEF_SYMBOL_BITS,
    localparam int NW  = $clog2(MAX_NODES),
    localparam int SW  = (SYMBOL_BITS < hbsd_pkg::SYM_W) ? SYMBOL_BITS : hbsd_pkg::SYM_W,
    localparam int EW  = 2 * NW + SW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  hbsd_pkg::t_item   i_item,
    output logic              o_res_valid,
    input  logic              i_res_free,
    output hbsd_pkg::t_result o_result,
    output logic              o_we,
    output logic [NW-1:0]     o_waddr,
    output logic [EW-1:0]     o_wdata,
    output logic [NW-1:0]     o_raddr,
    input  logic [EW-1:0]     i_rdata
);

    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int CLW   = $clog2(MAX_CODE_LEN + 1);
    localparam int BW    = 32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_DEC,
        S_CHK
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_used, n_used;
    logic [NW-1:0]       r_cur, n_cur;
    logic [2*NW-1:0]     r_cur_kids, n_cur_kids;
    logic [2*NW-1:0]     r_root_kids, n_root_kids;
    logic                r_failed, n_failed;
    logic [NW-1:0]       r_walk, n_walk;
    logic                r_fresh, n_fresh;
    logic [CLW-1:0]      r_i, n_i;
    logic [hbsd_pkg::CODE_W-1:0] r_bits, n_bits;
    logic [SW-1:0]       r_sym, n_sym;
    logic                r_bit, n_bit;
    logic [NW-1:0]       r_next, n_next;

    logic [2*NW-1:0]     rd_kids;
    logic [NW-1:0]       kl, kr, slot;
    logic                step_right;
    logic [BW-1:0]       bits_ext;
    logic [4:0]          bit_idx;
    logic                full;
    logic [NW-1:0]       new_idx;
    logic [2*NW-1:0]     dec_kids;
    logic [NW-1:0]       dec_next;
    logic signed [SW-1:0] sym_rd;
    logic [CLW-1:0]      len_sat;

    assign o_ready = (r_state == S_IDLE);

    // a freshly allocated node has no children yet; root children live in flops
    assign rd_kids = r_fresh ? '0 :
                     (r_walk == '0) ? r_root_kids : i_rdata[EW-1:SW];
    assign kl = rd_kids[2*NW-1:NW];
    assign kr = rd_kids[NW-1:0];

    assign bits_ext   = {{(BW - hbsd_pkg::CODE_W){1'b0}}, r_bits};
    assign bit_idx    = 5'(r_i - CLW'(1));
    assign step_right = bits_ext[bit_idx];
    assign slot       = step_right ? kr : kl;
    assign full       = (r_used == CNT_W'(MAX_NODES));
    assign new_idx    = r_used[NW-1:0];

    assign dec_kids = (r_cur == '0) ? r_root_kids : r_cur_kids;
    assign dec_next = r_bit ? dec_kids[NW-1:0] : dec_kids[2*NW-1:NW];
    assign sym_rd   = i_rdata[SW-1:0];

    assign len_sat = (32'(i_item.code_length) > MAX_CODE_LEN) ?
                     CLW'(MAX_CODE_LEN) : CLW'(i_item.code_length);

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_cur       = r_cur;
        n_cur_kids  = r_cur_kids;
        n_root_kids = r_root_kids;
        n_failed    = r_failed;
        n_walk      = r_walk;
        n_fresh     = r_fresh;
        n_i         = r_i;
        n_bits      = r_bits;
        n_sym       = r_sym;
        n_bit       = r_bit;
        n_next      = r_next;
        o_we        = 1'b0;
        o_waddr     = r_walk;
        o_wdata     = {rd_kids, sym_rd};
        o_raddr     = r_walk;
        o_res_valid = 1'b0;
        o_result    = '0;

        unique case (r_state)
            S_IDLE: begin
                o_raddr = '0;
                if (i_valid) begin
                    if (i_item.operation == hbsd_pkg::OP_INSERT) begin
                        n_cur   = '0;
                        n_walk  = '0;
                        n_fresh = 1'b0;
                        n_i     = len_sat;
                        n_bits  = i_item.code_bits;
                        n_sym   = i_item.code_symbol[SW-1:0];
                        n_state = S_INS;
                    end else begin
                        n_bit   = i_item.data_bit;
                        n_state = S_DEC;
                    end
                end
            end
            S_INS: begin
                if (r_i == '0) begin
                    if (i_res_free) begin
                        o_we            = 1'b1;
                        o_wdata         = {rd_kids, r_sym};
                        o_res_valid     = 1'b1;
                        o_result.status = hbsd_pkg::ST_OK;
                        n_state         = S_IDLE;
                    end
                end else if (slot == '0) begin
                    if (full) begin
                        // write back so a fresh node leaves a clean entry
                        if (i_res_free) begin
                            o_we            = 1'b1;
                            o_res_valid     = 1'b1;
                            o_result.status = hbsd_pkg::ST_FULL;
                            n_failed        = 1'b1;
                            n_state         = S_IDLE;
                        end
                    end else begin
                        o_we    = 1'b1;
                        o_wdata = step_right ? {kl, new_idx, sym_rd} : {new_idx, kr, sym_rd};
                        n_used  = r_used + CNT_W'(1);
                        n_walk  = new_idx;
                        n_fresh = 1'b1;
                        n_i     = r_i - CLW'(1);
                    end
                end else begin
                    o_raddr = slot;
                    n_walk  = slot;
                    n_fresh = 1'b0;
                    n_i     = r_i - CLW'(1);
                end
            end
            S_DEC: begin
                if (r_failed || dec_next == '0) begin
                    if (i_res_free) begin
                        o_res_valid     = 1'b1;
                        o_result.status = hbsd_pkg::ST_FAIL;
                        n_failed        = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else begin
                    o_raddr = dec_next;
                    n_next  = dec_next;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                o_raddr = r_next;
                if (i_res_free) begin
                    o_res_valid     = 1'b1;
                    o_result.status = hbsd_pkg::ST_OK;
                    if (i_rdata[EW-1:SW] == '0) begin
                        o_result.is_leaf = 1'b1;
                        o_result.symbol  = hbsd_pkg::SYM_W'(sym_rd);
                        n_cur            = '0;
                    end else begin
                        n_cur      = r_next;
                        n_cur_kids = i_rdata[EW-1:SW];
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_we && o_waddr == '0) begin
            n_root_kids = o_wdata[EW-1:SW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= CNT_W'(1);
            r_cur       <= '0;
            r_root_kids <= '0;
            r_failed    <= 1'b0;
            r_walk      <= '0;
            r_fresh     <= 1'b0;
            r_i         <= '0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_cur       <= n_cur;
            r_root_kids <= n_root_kids;
            r_failed    <= n_failed;
            r_walk      <= n_walk;
            r_fresh     <= n_fresh;
            r_i         <= n_i;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_kids <= n_cur_kids;
        r_bits     <= n_bits;
        r_sym      <= n_sym;
        r_bit      <= n_bit;
        r_next     <= n_next;
    end

endmodule

// File: sv/huffman_bit_serial_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_bit_serial_decoder: Huffman code tree builder and bit-serial decoder
// Code tree held in one node memory; one result per request.
// ----------------------------------------------------------------------------
// One request is handled at a time, and each gives exactly one result. A
// decode request passes through accept, child select and a leaf check on the
// read-back of the child's entry, or stops at child select when it reports
// failure; an insert of length L passes through accept, one step per tree
// level and a final symbol write, stopping early when the node store runs out.
// The steps are set by the single node memory with its registered read, and
// stall only while the result register waits on the downstream side. Each node
// entry is initialised when the node is allocated and the root's children
// sit in flops, so no clearing pass runs after reset.
module huffman_bit_serial_decoder #(
    parameter int MAX_NODES    = hbsd_pkg::DEF_MAX_NODES,
    parameter int MAX_CODE_LEN = hbsd_pkg::DEF_MAX_CODE_LEN,
    parameter int SYMBOL_BITS  = hbsd_pkg::DEF_SYMBOL_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // code_bits[15:0], code_length[20:16], code_symbol[36:21], data_bit[37]
    input  logic [hbsd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // operation[0]
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status[1:0], is_leaf[2], symbol[18:3]
    output logic [hbsd_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int SW = (SYMBOL_BITS < hbsd_pkg::SYM_W) ? SYMBOL_BITS : hbsd_pkg::SYM_W;
    localparam int EW = 2 * NW + SW;

    hbsd_pkg::t_item   item;
    hbsd_pkg::t_result res, out_res;
    logic              res_valid, res_free;
    logic              ram_we;
    logic [NW-1:0]     ram_waddr, ram_raddr;
    logic [EW-1:0]     ram_wdata, ram_rdata;

    assign item.operation   = s_axis_tuser;
    assign item.code_bits   = s_axis_tdata[hbsd_pkg::S_BITS_LSB +: hbsd_pkg::CODE_W];
    assign item.code_length = s_axis_tdata[hbsd_pkg::S_LEN_LSB +: hbsd_pkg::LEN_W];
    assign item.code_symbol = s_axis_tdata[hbsd_pkg::S_SYM_LSB +: hbsd_pkg::SYM_W];
    assign item.data_bit    = s_axis_tdata[hbsd_pkg::S_DBIT_LSB];

    hbsd_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_NODES)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    hbsd_ctrl #(
        .MAX_NODES    (MAX_NODES),
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_BITS  (SYMBOL_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_item      (item),
        .o_res_valid (res_valid),
        .i_res_free  (res_free),
        .o_result    (res),
        .o_we        (ram_we),
        .o_waddr     (ram_waddr),
        .o_wdata     (ram_wdata),
        .o_raddr     (ram_raddr),
        .i_rdata     (ram_rdata)
    );

    hbsd_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (res_valid),
        .o_ready  (res_free),
        .i_result (res),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_res)
    );

    assign m_axis_tdata = {
        {(hbsd_pkg::M_TDATA_W - hbsd_pkg::SYM_W - 1 - hbsd_pkg::STATUS_W){1'b0}},
        out_res.symbol, out_res.is_leaf, out_res.status
    };

`ifndef NO_ASSERTIONS
    // a result is only issued when the output register can take it
    a_res_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> res_free)
        else $error("result issued while output register full");

    // one request at a time: ready drops after every accepted request
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while previous one in flight");

    // a leaf result always reports success
    a_leaf_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && out_res.is_leaf) |-> (out_res.status == hbsd_pkg::ST_OK))
        else $error("leaf result with failure status");

    // symbol field is zero unless a codeword completed
    a_sym_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !out_res.is_leaf) |-> (out_res.symbol == '0))
        else $error("non-zero symbol on non-leaf result");
`endif

endmodule
